// ----- rtl/process_slot_ready_queue_manager_assert.svh -----
// Assertion helpers shared by the RTL of the ready queue manager.
`ifndef PROCESS_SLOT_READY_QUEUE_MANAGER_ASSERT_SVH
`define PROCESS_SLOT_READY_QUEUE_MANAGER_ASSERT_SVH

// Same-cycle implication, gated by the active-low reset.
`define PSRQ_ASSERT_IMP(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, gated by the active-low reset.
`define PSRQ_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/psrq_pkg.sv -----
`default_nettype none

package psrq_pkg;

	localparam int SLOT_COUNT  = 32;
	localparam int QUEUE_COUNT = 8;

	// Fixed transaction field widths.
	localparam int OP_W     = 3;
	localparam int SLOT_W   = 5;
	localparam int QSEL_W   = 3;
	localparam int STATUS_W = 2;

	// A link holds a slot index or the null value SLOT_COUNT.
	localparam int LINK_W = $clog2(SLOT_COUNT + 1);
	localparam int SIDX_W = $clog2(SLOT_COUNT);
	localparam int QIDX_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(SLOT_COUNT);

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 3'd0,
		OP_SCHED   = 3'd1,
		OP_UNSCHED = 3'd2,
		OP_RELEASE = 3'd3,
		OP_POP     = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_DECODE,
		FSM_LINK,
		FSM_SCHED2,
		FSM_WALK,
		FSM_WALK_CAP,
		FSM_UNLINK,
		FSM_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/psrq_ram.sv -----
`default_nettype none

module psrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/process_slot_ready_queue_manager.sv -----
// Release, spare opcodes, rejected ops, schedule onto an empty queue and taking a sole entry
// go from decode straight to done; other allocate and pop pass through the link state and
// other schedule through sched2; unschedule walks up to SLOT_COUNT hops, then unlinks a found target.
// One transaction in flight; the next is taken the cycle after the result is registered.
// Reset (arst_n low, async): all slots free in order, ready queues empty; link RAM entries
// read as "slot + 1" until written (valid bits).
`default_nettype none

`include "process_slot_ready_queue_manager_assert.svh"

module process_slot_ready_queue_manager (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [psrq_pkg::OP_W-1:0]       opcode,
	input  wire logic [psrq_pkg::SLOT_W-1:0]     slot,
	input  wire logic [psrq_pkg::QSEL_W-1:0]     queue_sel,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [psrq_pkg::STATUS_W-1:0]   status,
	output logic      [psrq_pkg::SLOT_W-1:0]     result_slot
);

	localparam int SC     = psrq_pkg::SLOT_COUNT;
	localparam int QC     = psrq_pkg::QUEUE_COUNT;
	localparam int LINK_W = psrq_pkg::LINK_W;
	localparam int SIDX_W = psrq_pkg::SIDX_W;
	localparam int QIDX_W = psrq_pkg::QIDX_W;
	localparam int SLOT_W = psrq_pkg::SLOT_W;
	localparam int QSEL_W = psrq_pkg::QSEL_W;
	localparam logic [LINK_W-1:0] NIL = psrq_pkg::NIL_LINK;

	// ---------------------------------------------------------------- state
	psrq_pkg::state_t  state_q, state_d;

	// List heads and tails, per-slot bookkeeping (small, read at one index each).
	logic [LINK_W-1:0] ready_head_q [QC];
	logic [LINK_W-1:0] ready_tail_q [QC];
	logic [LINK_W-1:0] free_head_q, free_tail_q;
	logic [QSEL_W-1:0] prio_q [SC];
	logic [SC-1:0]     in_use_q;
	logic [SC-1:0]     vld_q;          // link RAM entry has been written since reset

	// Latched transaction
	psrq_pkg::op_t     op_q;
	logic [SLOT_W-1:0] slot_q;
	logic [QSEL_W-1:0] qsel_q;
	logic [QIDX_W-1:0] qidx_q;         // queue touched by this op (prio for unschedule)
	logic              qok_q;          // that queue index is in range

	// Walk registers
	logic [LINK_W-1:0] cur_q, cur_d, prev_q, prev_d, steps_q, steps_d;

	// Pending result
	psrq_pkg::status_t st_q, st_d;
	logic [SLOT_W-1:0] res_q, res_d;

	// Output register
	logic                        out_valid_q;
	psrq_pkg::status_t           status_q;
	logic [SLOT_W-1:0]           result_slot_q;
	logic                        out_load;

	// ---------------------------------------------------------------- link RAM
	logic              ram_we, ram_re;
	logic [SIDX_W-1:0] ram_waddr, ram_raddr, raddr_s1;
	logic [LINK_W-1:0] ram_wdata, ram_rdata, rd_link;

	psrq_ram #(
		.WIDTH (LINK_W),
		.DEPTH (SC)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ram_re) begin
			raddr_s1 <= ram_raddr;
		end
	end

	// Unwritten entries still hold their reset chain: slot i -> i+1.
	assign rd_link = vld_q[raddr_s1] ? ram_rdata : LINK_W'(raddr_s1) + LINK_W'(1);

	// ---------------------------------------------------------------- decode helpers
	logic [SIDX_W-1:0] in_sidx;
	logic [QSEL_W-1:0] in_prio;
	logic              in_accept;
	logic [SIDX_W-1:0] s_idx, fh_idx;
	logic [LINK_W-1:0] s_link, q_head, q_tail, unl_head;
	logic              slot_ok, use_s, fh_nil, qh_nil, qt_nil, walk_more;

	assign in_accept = in_valid && in_ready;
	assign in_sidx   = SIDX_W'(slot);
	assign in_prio   = prio_q[in_sidx];

	assign s_idx   = SIDX_W'(slot_q);
	assign s_link  = LINK_W'(slot_q);
	assign slot_ok = slot_q < SC;
	assign use_s   = in_use_q[s_idx];
	assign fh_idx  = SIDX_W'(free_head_q);
	assign fh_nil  = free_head_q >= NIL;
	assign q_head  = ready_head_q[qidx_q];
	assign q_tail  = ready_tail_q[qidx_q];
	assign qh_nil  = q_head >= NIL;
	assign qt_nil  = q_tail >= NIL;

	// Keep walking while on a live entry that is not the target, within SLOT_COUNT hops.
	assign walk_more = (cur_q < NIL) && (cur_q != s_link) && (steps_q < NIL);

	// Head after the unlink: only changes when the target was the first entry.
	assign unl_head = (prev_q >= NIL) ? rd_link : q_head;

	// ---------------------------------------------------------------- sequencer
	logic              hd_we, tl_we, fh_we, ft_we, use_we, use_val, pri_we;
	logic [LINK_W-1:0] hd_wdata, tl_wdata, fh_wdata, ft_wdata;
	logic [SIDX_W-1:0] use_idx, pri_idx;
	logic [QSEL_W-1:0] pri_val;

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = s_idx;
		ram_wdata = NIL;
		ram_re    = 1'b0;
		ram_raddr = s_idx;
		hd_we     = 1'b0;
		hd_wdata  = NIL;
		tl_we     = 1'b0;
		tl_wdata  = NIL;
		fh_we     = 1'b0;
		fh_wdata  = NIL;
		ft_we     = 1'b0;
		ft_wdata  = NIL;
		use_we    = 1'b0;
		use_idx   = s_idx;
		use_val   = 1'b0;
		pri_we    = 1'b0;
		pri_idx   = s_idx;
		pri_val   = qsel_q;
		cur_d     = cur_q;
		prev_d    = prev_q;
		steps_d   = steps_q;
		res_d     = res_q;
		st_d      = st_q;
		out_load  = 1'b0;

		unique case (state_q)
			psrq_pkg::FSM_IDLE: begin
				if (in_valid) begin
					state_d = psrq_pkg::FSM_DECODE;
				end
			end

			psrq_pkg::FSM_DECODE: begin
				res_d   = '0;
				st_d    = psrq_pkg::ST_OK;
				state_d = psrq_pkg::FSM_DONE;
				unique case (op_q)
					psrq_pkg::OP_ALLOC: begin
						if (fh_nil) begin
							st_d = psrq_pkg::ST_EMPTY;
						end else begin
							res_d   = SLOT_W'(free_head_q);
							use_we  = 1'b1;
							use_idx = fh_idx;
							use_val = 1'b1;
							pri_we  = 1'b1;
							pri_idx = fh_idx;
							pri_val = '0;
							if (free_head_q == free_tail_q) begin
								// last free slot: list becomes empty
								fh_we     = 1'b1;
								ft_we     = 1'b1;
								ram_we    = 1'b1;
								ram_waddr = fh_idx;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = fh_idx;
								state_d   = psrq_pkg::FSM_LINK;
							end
						end
					end

					psrq_pkg::OP_SCHED: begin
						if (!slot_ok || !use_s || !qok_q) begin
							st_d = psrq_pkg::ST_NOT_FOUND;
						end else begin
							pri_we = 1'b1;
							tl_we    = 1'b1;
							tl_wdata = s_link;
							if (qh_nil || qt_nil) begin
								hd_we    = 1'b1;
								hd_wdata = s_link;
								ram_we   = 1'b1;
							end else begin
								// link old tail first, terminate the new entry next cycle
								ram_we    = 1'b1;
								ram_waddr = SIDX_W'(q_tail);
								ram_wdata = s_link;
								state_d   = psrq_pkg::FSM_SCHED2;
							end
						end
					end

					psrq_pkg::OP_UNSCHED: begin
						if (!slot_ok || !qok_q) begin
							st_d = psrq_pkg::ST_NOT_FOUND;
						end else begin
							cur_d   = q_head;
							prev_d  = NIL;
							steps_d = '0;
							state_d = psrq_pkg::FSM_WALK;
						end
					end

					psrq_pkg::OP_RELEASE: begin
						if (!slot_ok || !use_s) begin
							st_d = psrq_pkg::ST_NOT_FOUND;
						end else begin
							use_we   = 1'b1;
							use_val  = 1'b0;
							ram_we   = 1'b1;
							fh_we    = 1'b1;
							fh_wdata = s_link;
							if (fh_nil) begin
								ft_we    = 1'b1;
								ft_wdata = s_link;
							end else begin
								ram_wdata = free_head_q;
							end
						end
					end

					psrq_pkg::OP_POP: begin
						if (!qok_q || qh_nil) begin
							st_d = psrq_pkg::ST_EMPTY;
						end else begin
							res_d = SLOT_W'(q_head);
							if (q_head == q_tail) begin
								hd_we     = 1'b1;
								tl_we     = 1'b1;
								ram_we    = 1'b1;
								ram_waddr = SIDX_W'(q_head);
							end else begin
								ram_re    = 1'b1;
								ram_raddr = SIDX_W'(q_head);
								state_d   = psrq_pkg::FSM_LINK;
							end
						end
					end

					default: begin
						// undefined opcodes answer ok with no side effect
					end
				endcase
			end

			psrq_pkg::FSM_LINK: begin
				// popped or allocated entry's successor becomes the new ready or free head; detach the entry
				ram_we    = 1'b1;
				ram_waddr = raddr_s1;
				if (op_q == psrq_pkg::OP_ALLOC) begin
					fh_we    = 1'b1;
					fh_wdata = rd_link;
				end else begin
					hd_we    = 1'b1;
					hd_wdata = rd_link;
				end
				state_d = psrq_pkg::FSM_DONE;
			end

			psrq_pkg::FSM_SCHED2: begin
				ram_we  = 1'b1;
				state_d = psrq_pkg::FSM_DONE;
			end

			psrq_pkg::FSM_WALK: begin
				if (walk_more) begin
					ram_re    = 1'b1;
					ram_raddr = SIDX_W'(cur_q);
					state_d   = psrq_pkg::FSM_WALK_CAP;
				end else if (cur_q != s_link) begin
					st_d    = psrq_pkg::ST_NOT_FOUND;
					state_d = psrq_pkg::FSM_DONE;
				end else begin
					// found: fetch the target's successor
					ram_re  = 1'b1;
					state_d = psrq_pkg::FSM_UNLINK;
				end
			end

			psrq_pkg::FSM_WALK_CAP: begin
				prev_d  = cur_q;
				cur_d   = rd_link;
				steps_d = steps_q + LINK_W'(1);
				state_d = psrq_pkg::FSM_WALK;
			end

			psrq_pkg::FSM_UNLINK: begin
				if (prev_q >= NIL) begin
					hd_we    = 1'b1;
					hd_wdata = rd_link;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = SIDX_W'(prev_q);
					ram_wdata = rd_link;
				end
				if (unl_head >= NIL) begin
					tl_we = 1'b1;
				end else if (q_tail == cur_q) begin
					tl_we    = 1'b1;
					tl_wdata = prev_q;
				end
				state_d = psrq_pkg::FSM_DONE;
			end

			psrq_pkg::FSM_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = psrq_pkg::FSM_IDLE;
				end
			end
		endcase
	end

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psrq_pkg::FSM_IDLE;
			free_head_q <= '0;
			free_tail_q <= LINK_W'(SC - 1);
			in_use_q    <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < QC; i++) begin
				ready_head_q[i] <= NIL;
				ready_tail_q[i] <= NIL;
			end
			for (int i = 0; i < SC; i++) begin
				prio_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (hd_we) begin
				ready_head_q[qidx_q] <= hd_wdata;
			end
			if (tl_we) begin
				ready_tail_q[qidx_q] <= tl_wdata;
			end
			if (fh_we) begin
				free_head_q <= fh_wdata;
			end
			if (ft_we) begin
				free_tail_q <= ft_wdata;
			end
			if (use_we) begin
				in_use_q[use_idx] <= use_val;
			end
			if (pri_we) begin
				prio_q[pri_idx] <= pri_val;
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Transaction and datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q   <= psrq_pkg::op_t'(opcode);
			slot_q <= slot;
			qsel_q <= queue_sel;
			if (psrq_pkg::op_t'(opcode) == psrq_pkg::OP_UNSCHED) begin
				qidx_q <= QIDX_W'(in_prio);
				qok_q  <= in_prio < QC;
			end else begin
				qidx_q <= QIDX_W'(queue_sel);
				qok_q  <= queue_sel < QC;
			end
		end
		cur_q   <= cur_d;
		prev_q  <= prev_d;
		steps_q <= steps_d;
		st_q    <= st_d;
		res_q   <= res_d;
		if (out_load) begin
			status_q      <= st_q;
			result_slot_q <= res_q;
		end
	end

	assign in_ready    = state_q == psrq_pkg::FSM_IDLE;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign result_slot = result_slot_q;

	// ---------------------------------------------------------------- assertions
	`PSRQ_ASSERT_IMP(a_fail_zero_slot, clk, arst_n,
		out_valid && (status != psrq_pkg::ST_OK), result_slot == '0,
		"failed transaction carries a nonzero slot")
	`PSRQ_ASSERT_IMP(a_ram_no_collide, clk, arst_n,
		ram_we && ram_re, ram_waddr != ram_raddr,
		"link RAM read and write hit the same entry")
	`PSRQ_ASSERT_IMP(a_walk_bound, clk, arst_n,
		state_q == psrq_pkg::FSM_WALK_CAP, steps_q < NIL,
		"unschedule walk ran past the slot count")
	`PSRQ_ASSERT_NEXT(a_one_in_flight, clk, arst_n,
		in_accept, !in_ready,
		"second transaction taken while one is in flight")

endmodule

`default_nettype wire
